// File: design/cwb_pkg.sv
// ----------------------------------------------------------------------------
// cwb_pkg
// Shared types and constants of the coalescing write buffer.
// ----------------------------------------------------------------------------
package cwb_pkg;

    localparam int KIND_W     = 3;
    localparam int KEY_W      = 32;
    localparam int HANDLE_W   = 32;
    localparam int OP_W       = 2;
    localparam int TICK_W     = 16;
    localparam int INFLIGHT_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [INFLIGHT_W-1:0] INFLIGHT_MAX   = 4'd15;
    localparam logic [TICK_W-1:0]     INTERVAL_RESET = 16'd1000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_USABLE   = 1'b1;

    // result kinds
    localparam logic RES_REJECT = 1'b0;
    localparam logic RES_FLUSH  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 3'd0,
        KIND_UPDATE = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_CLEAR  = 3'd3,
        KIND_FLUSH  = 3'd4,
        KIND_TICK   = 3'd5,
        KIND_DONE   = 3'd6
    } t_kind;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_UPDATE  = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_REM_INS = 2'd3
    } t_op;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        t_op                 op;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    typedef struct packed {
        logic                result_kind;
        t_op                 op_code;
        logic [KEY_W-1:0]    out_key;
        logic [HANDLE_W-1:0] out_handle;
        logic                batch_dropped;
        logic                last;
    } t_result;

    // commands to the flush scheduler
    typedef struct packed {
        logic tick;
        logic stop;
        logic bump;
        logic dec;
        logic check;
        logic nonempty;
    } t_sched_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_MISS,
        ST_CHECK,
        ST_FL_RD,
        ST_FL_OUT
    } t_state;

endpackage

// File: design/cwb_req_if.sv
// ----------------------------------------------------------------------------
// cwb_req_if
// Request channel: valid/ready with kind, row key and cookie handle.
// ----------------------------------------------------------------------------
interface cwb_req_if import cwb_pkg::*;;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [KEY_W-1:0]    row_key;
    logic [HANDLE_W-1:0] cookie_handle;

    modport source (output valid, kind, row_key, cookie_handle, input ready);
    modport sink   (input valid, kind, row_key, cookie_handle, output ready);

endinterface

// File: design/cwb_res_if.sv
// ----------------------------------------------------------------------------
// cwb_res_if
// Result channel: valid/ready with one flushed entry or reject status.
// ----------------------------------------------------------------------------
interface cwb_res_if import cwb_pkg::*;;

    logic                valid;
    logic                ready;
    logic                result_kind;
    logic [OP_W-1:0]     op_code;
    logic [KEY_W-1:0]    out_key;
    logic [HANDLE_W-1:0] out_handle;
    logic                batch_dropped;
    logic                last;

    modport source (output valid, result_kind, op_code, out_key, out_handle,
                    batch_dropped, last, input ready);
    modport sink   (input valid, result_kind, op_code, out_key, out_handle,
                    batch_dropped, last, output ready);

endinterface

// File: design/cwb_table_mem.sv
// ----------------------------------------------------------------------------
// cwb_table_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cwb_table_mem import cwb_pkg::*; #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/cwb_sched.sv
// ----------------------------------------------------------------------------
// cwb_sched
// One-shot flush timer and saturating in-flight batch counter.
// ----------------------------------------------------------------------------
module cwb_sched import cwb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [TICK_W-1:0] i_interval,
    input  t_sched_ctl        i_ctl,
    output logic              o_expire
);

    logic                  r_running;
    logic                  n_running;
    logic [TICK_W-1:0]     r_remaining;
    logic [TICK_W-1:0]     n_remaining;
    logic [INFLIGHT_W-1:0] r_inflight;
    logic [INFLIGHT_W-1:0] n_inflight;

    always_comb begin
        n_running   = r_running;
        n_remaining = r_remaining;
        n_inflight  = r_inflight;
        o_expire    = i_ctl.tick && r_running && (r_remaining <= TICK_W'(1));

        if (i_ctl.tick && r_running) begin
            if (r_remaining <= TICK_W'(1)) begin
                n_remaining = '0;
                n_running   = 1'b0;
            end else begin
                n_remaining = r_remaining - TICK_W'(1);
            end
        end
        if (i_ctl.stop) begin
            n_running = 1'b0;
        end
        if (i_ctl.bump && (n_inflight != INFLIGHT_MAX)) begin
            n_inflight = n_inflight + INFLIGHT_W'(1);
        end
        if (i_ctl.dec && (n_inflight != '0)) begin
            n_inflight = n_inflight - INFLIGHT_W'(1);
        end
        // start the timer once work is pending and nothing else is going on
        if ((i_ctl.check || i_ctl.dec) && i_ctl.nonempty && !n_running
                && (n_inflight == '0)) begin
            n_running   = 1'b1;
            n_remaining = i_interval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_remaining <= '0;
            r_inflight  <= '0;
        end else begin
            r_running   <= n_running;
            r_remaining <= n_remaining;
            r_inflight  <= n_inflight;
        end
    end

endmodule

// File: design/coalescing_write_buffer.sv
// ----------------------------------------------------------------------------
// coalescing_write_buffer
// Table of pending row writes, merged per key and flushed as one batch.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  i_req     in   valid/ready        kind, row_key, cookie_handle
//  o_res     out  valid/ready        result_kind, op_code, out_key,
//                                    out_handle, batch_dropped, last
//  i_cfg_*   in   write enable only  i_cfg_idx, i_cfg_data
//
//  Insert/update/remove: a key search, then a merge on a hit or a new
//  entry on a miss. The key search reads the entry memory one slot per
//  cycle. Clear, tick, flush completed: handled in the idle state. A flush
//  steps over empty slots below the highest valid one and gives each valid
//  slot a memory read, then a result load. Reset is synchronous, active
//  low; the memory needs no clearing, as per-slot valid bits sit in flops.
//  The output register decouples the sides: a new request is taken while a
//  result waits, and result producing steps stall while it is still full.
//
module coalescing_write_buffer import cwb_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cwb_req_if.sink               i_req,
    cwb_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam logic [IW-1:0] LastIdx = IW'(TABLE_DEPTH - 1);
    localparam logic [IW:0]   IdxEnd  = (IW + 1)'(TABLE_DEPTH);

    // configuration
    logic [TICK_W-1:0] r_interval;
    logic              r_usable;

    // control state
    t_state                 r_state;
    t_state                 n_state;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [TABLE_DEPTH-1:0] n_valid;
    logic [IW:0]            r_idx;
    logic [IW:0]            n_idx;
    logic                   r_cmp_vld;
    logic                   n_cmp_vld;
    logic [IW-1:0]          r_cmp_idx;
    logic [IW-1:0]          n_cmp_idx;
    logic [IW-1:0]          r_slot;
    logic [IW-1:0]          n_slot;
    t_op                    r_old_op;
    t_op                    n_old_op;
    t_kind                  r_kind;
    t_kind                  n_kind;
    logic [KEY_W-1:0]       r_key;
    logic [KEY_W-1:0]       n_key;
    logic [HANDLE_W-1:0]    r_handle;
    logic [HANDLE_W-1:0]    n_handle;
    logic                   r_dropped;
    logic                   n_dropped;

    // output register
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;
    t_result n_out;

    // memory ports
    logic    mem_we;
    logic    [IW-1:0] mem_waddr;
    t_entry  mem_wdata;
    logic    mem_re;
    logic    [IW-1:0] mem_raddr;
    t_entry  mem_rd;

    // scheduler
    t_sched_ctl sched_ctl;
    logic       sched_expire;

    logic                   out_free;
    logic                   free_found;
    logic [IW-1:0]          free_idx;
    logic                   start_flush;
    logic                   hit;
    logic [TABLE_DEPTH-1:0] slot_bit;
    logic                   last_slot;

    cwb_table_mem #(
        .DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rd)
    );

    cwb_sched u_sched (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_interval (r_interval),
        .i_ctl      (sched_ctl),
        .o_expire   (sched_expire)
    );

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    assign out_free  = !r_out_valid || o_res.ready;
    assign hit       = r_cmp_vld && r_valid[r_cmp_idx] && (mem_rd.key == r_key);
    assign slot_bit  = TABLE_DEPTH'(1) << r_idx[IW-1:0];
    // valid bits below the walk pointer are already cleared
    assign last_slot = ((r_valid & ~slot_bit) == '0);

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_idx       = r_idx;
        n_cmp_vld   = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_slot      = r_slot;
        n_old_op    = r_old_op;
        n_kind      = r_kind;
        n_key       = r_key;
        n_handle    = r_handle;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;

        mem_we      = 1'b0;
        mem_waddr   = r_slot;
        mem_wdata   = '{key: r_key, op: t_op'(r_kind[OP_W-1:0]), handle: r_handle};
        mem_re      = 1'b0;
        mem_raddr   = r_idx[IW-1:0];

        sched_ctl          = '0;
        sched_ctl.nonempty = |r_valid;
        start_flush        = 1'b0;
        i_req.ready        = (r_state == ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_kind   = t_kind'(i_req.kind);
                    n_key    = i_req.row_key;
                    n_handle = i_req.cookie_handle;
                    case (t_kind'(i_req.kind)) inside
                        KIND_INSERT, KIND_UPDATE, KIND_REMOVE: begin
                            n_idx   = '0;
                            n_state = ST_SCAN;
                        end
                        KIND_CLEAR: begin
                            n_valid        = '0;
                            sched_ctl.stop = 1'b1;
                        end
                        KIND_FLUSH: begin
                            sched_ctl.stop = 1'b1;
                            start_flush    = 1'b1;
                        end
                        KIND_TICK: begin
                            sched_ctl.tick = 1'b1;
                            start_flush    = sched_expire;
                        end
                        KIND_DONE: begin
                            sched_ctl.dec = 1'b1;
                        end
                        default: ;
                    endcase
                    // an empty table flushes to nothing and leaves the count
                    if (start_flush && (|r_valid)) begin
                        sched_ctl.bump = r_usable;
                        n_dropped      = !r_usable;
                        n_idx          = '0;
                        n_state        = ST_FL_RD;
                    end
                end
            end

            // one memory read per cycle, compare in the cycle after the read
            ST_SCAN: begin
                if (hit) begin
                    n_slot   = r_cmp_idx;
                    n_old_op = mem_rd.op;
                    n_state  = ST_APPLY;
                end else if (r_cmp_vld && (r_cmp_idx == LastIdx)) begin
                    n_state = ST_MISS;
                end else if (r_idx != IdxEnd) begin
                    mem_re    = 1'b1;
                    n_idx     = r_idx + (IW + 1)'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[IW-1:0];
                end
            end

            // merge into the pending entry
            ST_APPLY: begin
                n_state = ST_CHECK;
                case (r_kind)
                    KIND_INSERT: begin
                        mem_we       = 1'b1;
                        mem_wdata.op = OP_REM_INS;
                    end
                    KIND_UPDATE: begin
                        mem_we       = 1'b1;
                        mem_wdata.op = r_old_op;
                    end
                    default: begin
                        // remove cancels a pending insert outright
                        if (r_old_op == OP_INSERT) begin
                            n_valid[r_slot] = 1'b0;
                        end else begin
                            mem_we       = 1'b1;
                            mem_wdata.op = OP_REMOVE;
                        end
                    end
                endcase
            end

            ST_MISS: begin
                if (free_found) begin
                    mem_we            = 1'b1;
                    mem_waddr         = free_idx;
                    n_valid[free_idx] = 1'b1;
                    n_state           = ST_CHECK;
                end else if (out_free) begin
                    // table full: report the request back
                    n_out_valid         = 1'b1;
                    n_out.result_kind   = RES_REJECT;
                    n_out.op_code       = t_op'(r_kind[OP_W-1:0]);
                    n_out.out_key       = r_key;
                    n_out.out_handle    = r_handle;
                    n_out.batch_dropped = 1'b0;
                    n_out.last          = 1'b1;
                    n_state             = ST_CHECK;
                end
            end

            ST_CHECK: begin
                sched_ctl.check = 1'b1;
                n_state         = ST_IDLE;
            end

            // flush walk in slot order
            ST_FL_RD: begin
                if (r_valid[r_idx[IW-1:0]]) begin
                    mem_re  = 1'b1;
                    n_state = ST_FL_OUT;
                end else begin
                    n_idx = r_idx + (IW + 1)'(1);
                end
            end

            ST_FL_OUT: begin
                if (out_free) begin
                    n_out_valid               = 1'b1;
                    n_out.result_kind         = RES_FLUSH;
                    n_out.op_code             = mem_rd.op;
                    n_out.out_key             = mem_rd.key;
                    n_out.out_handle          = mem_rd.handle;
                    n_out.batch_dropped       = r_dropped;
                    n_out.last                = last_slot;
                    n_valid[r_idx[IW-1:0]]    = 1'b0;
                    if (last_slot) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + (IW + 1)'(1);
                        n_state = ST_FL_RD;
                    end
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_slot    <= n_slot;
        r_old_op  <= n_old_op;
        r_kind    <= n_kind;
        r_key     <= n_key;
        r_handle  <= n_handle;
        r_dropped <= n_dropped;
        r_out     <= n_out;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RESET;
            r_usable   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INTERVAL: r_interval <= i_cfg_data;
                CFG_USABLE:   r_usable   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.result_kind   = r_out.result_kind;
    assign o_res.op_code       = r_out.op_code;
    assign o_res.out_key       = r_out.out_key;
    assign o_res.out_handle    = r_out.out_handle;
    assign o_res.batch_dropped = r_out.batch_dropped;
    assign o_res.last          = r_out.last;

endmodule
